@@ rtl/pcrr_pkg.sv @@
// shared constants, types and codes of the packet capture record ring
// no dependencies; pcrr_ctrl, pcrr_dp and the top level refer to it by scoped name
package pcrr_pkg;

    localparam int RING_BYTES_DEF  = 1024;
    localparam int FRAME_BYTES_DEF = 64;

    localparam int HDR_LEN   = 3;
    localparam int FRAME_HDR = 4;
    localparam int LIM_SMALL = 4;
    localparam int LIM_INTR  = 8;
    localparam int REC_W     = 9;

    localparam logic [7:0]  CAP_MAGIC = 8'hC2;
    localparam logic [7:0]  BYTE_MAX  = 8'hFF;
    localparam logic [15:0] DROP_MAX  = 16'hFFFF;

    localparam logic [1:0] MODE_START   = 2'd0;
    localparam logic [1:0] MODE_PAYLOAD = 2'd1;
    localparam logic [1:0] MODE_POLL    = 2'd2;

    localparam logic [1:0] TT_BULK = 2'd2;
    localparam logic [1:0] TT_INTR = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HDR_LEN,
        ST_HDR_ORIG,
        ST_SCAN_ISSUE,
        ST_SCAN_CHECK,
        ST_PRIME,
        ST_EMIT
    } state_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_START,
        CMD_HDR_LEN,
        CMD_HDR_ORIG,
        CMD_PAYLOAD,
        CMD_POLL,
        CMD_SCAN_ISSUE,
        CMD_SCAN_CHECK,
        CMD_PRIME,
        CMD_EMIT
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t op;
    } cmd_t;

    typedef struct packed {
        logic no_room;
        logic pending;
        logic scan_more;
        logic scan_fit;
        logic emit_last;
        logic out_free;
    } status_t;

endpackage

@@ rtl/pcrr_if.sv @@
// valid/ready channel interfaces: capture input items and frame output bytes
// no dependencies
interface pcrr_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic        to_host;
    logic [7:0]  endpoint;
    logic [1:0]  xfer_type;
    logic [15:0] packet_length;
    logic [7:0]  payload_byte;

    modport source (
        output valid, mode, to_host, endpoint, xfer_type, packet_length,
               payload_byte,
        input  ready
    );
    modport sink (
        input  valid, mode, to_host, endpoint, xfer_type, packet_length,
               payload_byte,
        output ready
    );
endinterface

interface pcrr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_last;

    modport source (
        output valid, frame_byte, frame_last,
        input  ready
    );
    modport sink (
        input  valid, frame_byte, frame_last,
        output ready
    );
endinterface

@@ rtl/pcrr_ram.sv @@
// generic simple dual-port ram: one write port, one registered read port
// no dependencies
module pcrr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/pcrr_ctrl.sv @@
// controller state machine: sequences header writes, frame scan and frame output
// depends on pcrr_pkg
module pcrr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [1:0]        in_mode,
    input  pcrr_pkg::status_t status,
    output logic              in_ready,
    output pcrr_pkg::cmd_t    cmd
);

    pcrr_pkg::state_t state_reg;
    pcrr_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pcrr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = pcrr_pkg::CMD_NONE;
        in_ready   = 1'b0;
        unique case (state_reg)
            pcrr_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    unique case (in_mode)
                        pcrr_pkg::MODE_START:
                        begin
                            cmd.op = pcrr_pkg::CMD_START;
                            if (!status.no_room)
                            begin
                                state_next = pcrr_pkg::ST_HDR_LEN;
                            end
                        end
                        pcrr_pkg::MODE_PAYLOAD:
                        begin
                            cmd.op = pcrr_pkg::CMD_PAYLOAD;
                        end
                        pcrr_pkg::MODE_POLL:
                        begin
                            cmd.op     = pcrr_pkg::CMD_POLL;
                            state_next = status.pending ? pcrr_pkg::ST_SCAN_ISSUE
                                                        : pcrr_pkg::ST_PRIME;
                        end
                        default:
                        begin
                            cmd.op = pcrr_pkg::CMD_NONE;
                        end
                    endcase
                end
            end
            pcrr_pkg::ST_HDR_LEN:
            begin
                cmd.op     = pcrr_pkg::CMD_HDR_LEN;
                state_next = pcrr_pkg::ST_HDR_ORIG;
            end
            pcrr_pkg::ST_HDR_ORIG:
            begin
                cmd.op     = pcrr_pkg::CMD_HDR_ORIG;
                state_next = pcrr_pkg::ST_IDLE;
            end
            pcrr_pkg::ST_SCAN_ISSUE:
            begin
                if (status.scan_more)
                begin
                    cmd.op     = pcrr_pkg::CMD_SCAN_ISSUE;
                    state_next = pcrr_pkg::ST_SCAN_CHECK;
                end
                else
                begin
                    state_next = pcrr_pkg::ST_PRIME;
                end
            end
            pcrr_pkg::ST_SCAN_CHECK:
            begin
                cmd.op     = pcrr_pkg::CMD_SCAN_CHECK;
                state_next = status.scan_fit ? pcrr_pkg::ST_SCAN_ISSUE
                                             : pcrr_pkg::ST_PRIME;
            end
            pcrr_pkg::ST_PRIME:
            begin
                cmd.op     = pcrr_pkg::CMD_PRIME;
                state_next = pcrr_pkg::ST_EMIT;
            end
            pcrr_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.op = pcrr_pkg::CMD_EMIT;
                    if (status.emit_last)
                    begin
                        state_next = pcrr_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = pcrr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/pcrr_dp.sv @@
// datapath: ring ram, pointers, counters, record scan and frame output register
// depends on pcrr_pkg and pcrr_ram
module pcrr_dp #(
    parameter int RING_BYTES  = pcrr_pkg::RING_BYTES_DEF,
    parameter int FRAME_BYTES = pcrr_pkg::FRAME_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pcrr_pkg::cmd_t    cmd,
    output pcrr_pkg::status_t status,
    input  logic              to_host,
    input  logic [7:0]        endpoint,
    input  logic [1:0]        xfer_type,
    input  logic [15:0]       packet_length,
    input  logic [7:0]        payload_byte,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [7:0]        out_byte,
    output logic              out_last
);

    localparam int PTR_W   = $clog2(RING_BYTES);
    localparam int FILL_W  = $clog2(RING_BYTES + 1);
    localparam int CAP     = FRAME_BYTES - pcrr_pkg::FRAME_HDR - pcrr_pkg::HDR_LEN;
    localparam int LEN_W   = $clog2(CAP + 1);
    localparam int CNT_W   = $clog2(FRAME_BYTES + 1);
    localparam int IDX_W   = $clog2(FRAME_BYTES);
    localparam int SUM_W   = pcrr_pkg::REC_W + 1;
    localparam int THREE_Q = RING_BYTES * 3 / 4;
    localparam int HALF    = RING_BYTES / 2;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(RING_BYTES - 1)) ? '0 : p + 1'b1;
    endfunction

    // control state
    logic [PTR_W-1:0]  wp_reg, wp_next;
    logic [PTR_W-1:0]  rp_reg, rp_next;
    logic [PTR_W-1:0]  owp_reg, owp_next;
    logic [PTR_W-1:0]  hp_reg, hp_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [15:0]       drop_reg, drop_next;
    logic [7:0]        seq_reg, seq_next;
    logic [LEN_W-1:0]  bts_reg, bts_next;
    logic [LEN_W-1:0]  orl_reg, orl_next;
    logic              open_reg, open_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              out_valid_reg, out_valid_next;

    // payload state
    logic [LEN_W-1:0]  kept_reg, kept_next;
    logic [7:0]        orig_reg, orig_next;
    logic [7:0]        hdr_seq_reg, hdr_seq_next;
    logic [7:0]        hdr_rep_reg, hdr_rep_next;
    logic              zero_reg, zero_next;
    logic [PTR_W-1:0]  scan_ptr_reg, scan_ptr_next;
    logic [FILL_W-1:0] scan_fill_reg, scan_fill_next;
    logic [CNT_W-1:0]  scan_pos_reg, scan_pos_next;
    logic [7:0]        packed_reg, packed_next;
    logic [CNT_W-1:0]  total_reg, total_next;
    logic [7:0]        out_byte_reg, out_byte_next;
    logic              out_last_reg, out_last_next;

    // ram ports
    logic              ram_we;
    logic [PTR_W-1:0]  ram_waddr;
    logic [7:0]        ram_wdata;
    logic              ram_re;
    logic [PTR_W-1:0]  ram_raddr;
    logic [7:0]        ram_rdata;

    logic [LEN_W-1:0]         lim;
    logic [LEN_W-1:0]         kept;
    logic                     ge3q;
    logic                     gehalf;
    logic [FILL_W-1:0]        avail;
    logic                     no_room;
    logic [pcrr_pkg::REC_W-1:0] rec;
    logic                     scan_fit;
    logic [PTR_W:0]           ptr_sum;
    logic [PTR_W-1:0]         ptr_wrap;
    logic [CNT_W-1:0]         idx_c;
    logic                     is_rec;
    logic [7:0]               emit_byte;

    pcrr_ram #(
        .WIDTH (8),
        .DEPTH (RING_BYTES)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // kept length and room check for a packet start
    always_comb
    begin
        ge3q   = fill_reg >= FILL_W'(THREE_Q);
        gehalf = fill_reg >= FILL_W'(HALF);
        lim    = LEN_W'(CAP);
        if (xfer_type == pcrr_pkg::TT_BULK)
        begin
            if (ge3q)
            begin
                lim = '0;
            end
            else if (gehalf)
            begin
                lim = LEN_W'(pcrr_pkg::LIM_SMALL);
            end
        end
        else if (xfer_type == pcrr_pkg::TT_INTR)
        begin
            if (ge3q)
            begin
                lim = LEN_W'(pcrr_pkg::LIM_INTR);
            end
        end
        else if (ge3q)
        begin
            lim = LEN_W'(pcrr_pkg::LIM_SMALL);
        end
        kept    = (packet_length < 16'(lim)) ? packet_length[LEN_W-1:0] : lim;
        avail   = FILL_W'(RING_BYTES) - fill_reg;
        no_room = avail < (FILL_W'(pcrr_pkg::HDR_LEN) + FILL_W'(kept));
    end

    // record scan: length byte comes back from the ram
    always_comb
    begin
        rec      = pcrr_pkg::REC_W'(pcrr_pkg::HDR_LEN) + pcrr_pkg::REC_W'(ram_rdata);
        scan_fit = (scan_fill_reg >= FILL_W'(rec))
                   && ((SUM_W'(scan_pos_reg) + SUM_W'(rec)) <= SUM_W'(FRAME_BYTES));
        ptr_sum  = (PTR_W + 1)'(scan_ptr_reg) + (PTR_W + 1)'(rec);
        if (ptr_sum >= (PTR_W + 1)'(RING_BYTES))
        begin
            ptr_wrap = PTR_W'(ptr_sum - (PTR_W + 1)'(RING_BYTES));
        end
        else
        begin
            ptr_wrap = ptr_sum[PTR_W-1:0];
        end
    end

    // frame byte selection
    always_comb
    begin
        idx_c  = CNT_W'(idx_reg);
        is_rec = !zero_reg && (idx_c >= CNT_W'(pcrr_pkg::FRAME_HDR))
                 && (idx_c < total_reg + CNT_W'(pcrr_pkg::FRAME_HDR));
        priority if (zero_reg)
        begin
            emit_byte = '0;
        end
        else if (idx_c == CNT_W'(0))
        begin
            emit_byte = pcrr_pkg::CAP_MAGIC;
        end
        else if (idx_c == CNT_W'(1))
        begin
            emit_byte = hdr_seq_reg;
        end
        else if (idx_c == CNT_W'(2))
        begin
            emit_byte = hdr_rep_reg;
        end
        else if (idx_c == CNT_W'(3))
        begin
            emit_byte = packed_reg;
        end
        else if (is_rec)
        begin
            emit_byte = ram_rdata;
        end
        else
        begin
            emit_byte = '0;
        end
    end

    assign status.no_room   = no_room;
    assign status.pending   = (fill_reg != '0) || (drop_reg != '0);
    assign status.scan_more = scan_fill_reg >= FILL_W'(pcrr_pkg::HDR_LEN);
    assign status.scan_fit  = scan_fit;
    assign status.emit_last = idx_reg == IDX_W'(FRAME_BYTES - 1);
    assign status.out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        owp_next       = owp_reg;
        hp_next        = hp_reg;
        fill_next      = fill_reg;
        drop_next      = drop_reg;
        seq_next       = seq_reg;
        bts_next       = bts_reg;
        orl_next       = orl_reg;
        open_next      = open_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        kept_next      = kept_reg;
        orig_next      = orig_reg;
        hdr_seq_next   = hdr_seq_reg;
        hdr_rep_next   = hdr_rep_reg;
        zero_next      = zero_reg;
        scan_ptr_next  = scan_ptr_reg;
        scan_fill_next = scan_fill_reg;
        scan_pos_next  = scan_pos_reg;
        packed_next    = packed_reg;
        total_next     = total_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        ram_we         = 1'b0;
        ram_waddr      = wp_reg;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = rp_reg;
        unique case (cmd.op)
            pcrr_pkg::CMD_START:
            begin
                open_next = 1'b0;
                bts_next  = '0;
                if (no_room)
                begin
                    if (drop_reg != pcrr_pkg::DROP_MAX)
                    begin
                        drop_next = drop_reg + 16'd1;
                    end
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = wp_reg;
                    ram_wdata = {to_host, endpoint[6:0]};
                    hp_next   = ring_next(wp_reg);
                    kept_next = kept;
                    orig_next = (packet_length > 16'(pcrr_pkg::BYTE_MAX))
                                ? pcrr_pkg::BYTE_MAX : packet_length[7:0];
                end
            end
            pcrr_pkg::CMD_HDR_LEN:
            begin
                ram_we    = 1'b1;
                ram_waddr = hp_reg;
                ram_wdata = 8'(kept_reg);
                hp_next   = ring_next(hp_reg);
            end
            pcrr_pkg::CMD_HDR_ORIG:
            begin
                ram_we    = 1'b1;
                ram_waddr = hp_reg;
                ram_wdata = orig_reg;
                owp_next  = ring_next(hp_reg);
                orl_next  = kept_reg;
                if (kept_reg == '0)
                begin
                    // empty payload commits at once
                    wp_next   = ring_next(hp_reg);
                    fill_next = fill_reg + FILL_W'(pcrr_pkg::HDR_LEN);
                end
                else
                begin
                    bts_next  = kept_reg;
                    open_next = 1'b1;
                end
            end
            pcrr_pkg::CMD_PAYLOAD:
            begin
                if (open_reg && (bts_reg != '0))
                begin
                    ram_we    = 1'b1;
                    ram_waddr = owp_reg;
                    ram_wdata = payload_byte;
                    owp_next  = ring_next(owp_reg);
                    bts_next  = bts_reg - 1'b1;
                    if (bts_reg == LEN_W'(1))
                    begin
                        wp_next   = ring_next(owp_reg);
                        fill_next = fill_reg + FILL_W'(pcrr_pkg::HDR_LEN) + FILL_W'(orl_reg);
                        open_next = 1'b0;
                    end
                end
            end
            pcrr_pkg::CMD_POLL:
            begin
                zero_next      = !status.pending;
                hdr_seq_next   = seq_reg;
                hdr_rep_next   = (drop_reg > 16'(pcrr_pkg::BYTE_MAX))
                                 ? pcrr_pkg::BYTE_MAX : drop_reg[7:0];
                scan_ptr_next  = rp_reg;
                scan_fill_next = fill_reg;
                scan_pos_next  = CNT_W'(pcrr_pkg::FRAME_HDR);
                packed_next    = '0;
                total_next     = '0;
            end
            pcrr_pkg::CMD_SCAN_ISSUE:
            begin
                ram_re    = 1'b1;
                ram_raddr = ring_next(scan_ptr_reg);
            end
            pcrr_pkg::CMD_SCAN_CHECK:
            begin
                if (scan_fit)
                begin
                    packed_next    = packed_reg + 8'd1;
                    total_next     = total_reg + CNT_W'(rec);
                    scan_pos_next  = scan_pos_reg + CNT_W'(rec);
                    scan_fill_next = scan_fill_reg - FILL_W'(rec);
                    scan_ptr_next  = ptr_wrap;
                end
            end
            pcrr_pkg::CMD_PRIME:
            begin
                // first record byte is fetched ahead of the output
                ram_re    = 1'b1;
                ram_raddr = rp_reg;
                idx_next  = '0;
                if (!zero_reg)
                begin
                    seq_next  = seq_reg + 8'd1;
                    drop_next = drop_reg - 16'(hdr_rep_reg);
                    fill_next = fill_reg - FILL_W'(total_reg);
                end
            end
            pcrr_pkg::CMD_EMIT:
            begin
                out_valid_next = 1'b1;
                out_byte_next  = emit_byte;
                out_last_next  = status.emit_last;
                idx_next       = idx_reg + 1'b1;
                if (is_rec)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = ring_next(rp_reg);
                    rp_next   = ring_next(rp_reg);
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            rp_reg        <= '0;
            owp_reg       <= '0;
            hp_reg        <= '0;
            fill_reg      <= '0;
            drop_reg      <= '0;
            seq_reg       <= '0;
            bts_reg       <= '0;
            orl_reg       <= '0;
            open_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            owp_reg       <= owp_next;
            hp_reg        <= hp_next;
            fill_reg      <= fill_next;
            drop_reg      <= drop_next;
            seq_reg       <= seq_next;
            bts_reg       <= bts_next;
            orl_reg       <= orl_next;
            open_reg      <= open_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kept_reg      <= kept_next;
        orig_reg      <= orig_next;
        hdr_seq_reg   <= hdr_seq_next;
        hdr_rep_reg   <= hdr_rep_next;
        zero_reg      <= zero_next;
        scan_ptr_reg  <= scan_ptr_next;
        scan_fill_reg <= scan_fill_next;
        scan_pos_reg  <= scan_pos_next;
        packed_reg    <= packed_next;
        total_reg     <= total_next;
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(RING_BYTES))
        else $error("fill count beyond ring size");

    a_open_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg |-> (bts_reg != '0))
        else $error("open record with nothing left to store");

    a_start_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == pcrr_pkg::CMD_START) |=> !open_reg)
        else $error("record still open after packet start");

    a_scan_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == pcrr_pkg::CMD_SCAN_CHECK) |=> (scan_pos_reg <= CNT_W'(FRAME_BYTES)))
        else $error("scan packed past frame end");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == pcrr_pkg::CMD_EMIT) |-> (!out_valid_reg || out_ready))
        else $error("frame byte overwrote an untaken transfer");

endmodule

@@ rtl/packet_capture_record_ring.sv @@
// top level of the packet capture record ring
// depends on pcrr_pkg, pcrr_if, pcrr_ram, pcrr_ctrl and pcrr_dp
//
// cap_in carries one item per transfer: mode 0 starts a packet record, mode 1
// adds a payload byte, mode 2 polls for a frame, mode 3 is ignored.
// frame_out carries the poll reply, FRAME_BYTES transfers with frame_last on
// the final one.
// a payload byte or ignored item is taken at once; a packet start writes three
// header bytes through the single ram write port, unless dropped. a poll scans
// the records one by one, reading each length byte, until one does not fit (no
// scan when nothing is pending), fetches the first record byte, then gives out
// FRAME_BYTES bytes, one byte per cycle while frame_out does not stall.
// cap_in is not ready while a start or a poll is in progress.
// the last frame byte sits in the output register; new items are taken while
// it waits. when frame_out stalls, frame output simply holds until taken.
// reset clears pointers, counters and the open record; ring contents stay
// undefined and are only read once written, so there is no clearing pass.
module packet_capture_record_ring #(
    parameter int RING_BYTES  = pcrr_pkg::RING_BYTES_DEF,
    parameter int FRAME_BYTES = pcrr_pkg::FRAME_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    pcrr_in_if.sink     cap_in,
    pcrr_out_if.source  frame_out
);

    pcrr_pkg::cmd_t    cmd;
    pcrr_pkg::status_t status;

    pcrr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cap_in.valid),
        .in_mode  (cap_in.mode),
        .status   (status),
        .in_ready (cap_in.ready),
        .cmd      (cmd)
    );

    pcrr_dp #(
        .RING_BYTES  (RING_BYTES),
        .FRAME_BYTES (FRAME_BYTES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .to_host       (cap_in.to_host),
        .endpoint      (cap_in.endpoint),
        .xfer_type     (cap_in.xfer_type),
        .packet_length (cap_in.packet_length),
        .payload_byte  (cap_in.payload_byte),
        .out_ready     (frame_out.ready),
        .out_valid     (frame_out.valid),
        .out_byte      (frame_out.frame_byte),
        .out_last      (frame_out.frame_last)
    );

endmodule
